// ===== hw/rtl/sdiv_pkg.sv =====
// package for the saturating signed divider
// holds the default operand width and the sequencer state type; no dependencies

package sdiv_pkg;

  // default operand and quotient width
  localparam int SDIV_DATA_WIDTH = 32;

  // divider sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } sdiv_state_t;

endpackage

// ===== hw/rtl/sdiv_step.sv =====
// one restoring division step: shift in a dividend bit, compare, subtract
// shared by every quotient bit of an item; uses sdiv_pkg for the default width

module sdiv_step #(
  parameter int DATA_WIDTH = sdiv_pkg::SDIV_DATA_WIDTH
) (
  input  logic [DATA_WIDTH-1:0] rem,
  input  logic                  dd_bit,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic [DATA_WIDTH-1:0] rem_next,
  output logic                  q_bit
);
  import sdiv_pkg::*;

  logic [DATA_WIDTH-1:0] rem_shift;
  logic [DATA_WIDTH-1:0] rem_sub;

  // for a nonzero divisor the partial remainder stays below it, so its top bit is zero
  assign rem_shift = {rem[DATA_WIDTH-2:0], dd_bit};
  assign rem_sub   = rem_shift - divisor;

  // restore when the subtraction would go negative
  assign q_bit    = (rem_shift >= divisor);
  assign rem_next = q_bit ? rem_sub : rem_shift;

endmodule

// ===== hw/rtl/signed_divider_saturating_unit.sv =====
// Signed integer divider with saturation: quotient = numerator / denominator, truncated
// toward zero. An item passes through these steps in order: taking the operand magnitudes,
// DATA_WIDTH steps of the single shared compare-subtract unit producing one quotient bit
// each, and sign fix-up, which waits while the output register still holds an untaken
// result. in_ready is high only while the sequencer is idle. The result sits in an output
// register, so a new item is taken while the previous quotient still waits for out_ready.
// A zero divisor, and the most negative value divided by minus one, give the largest
// positive value. No remainder is produced and no state is kept between items.
// Depends on sdiv_pkg and sdiv_step.

module signed_divider_saturating_unit #(
  parameter int DATA_WIDTH = sdiv_pkg::SDIV_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] numerator,
  input  logic signed [DATA_WIDTH-1:0] denominator,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] quotient
);
  import sdiv_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ONE     = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [CNT_W-1:0]      LAST_BIT = CNT_W'(DATA_WIDTH - 1);

  sdiv_state_t state, state_next;
  logic                  out_valid_next;
  logic                  load_out;
  logic                  accept;

  // working registers
  logic [DATA_WIDTH-1:0] dq;        // dividend bits shift out, quotient bits shift in
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] divisor;
  logic [CNT_W-1:0]      cnt;
  logic                  neg;
  logic                  div_zero;

  // operand magnitudes
  logic [DATA_WIDTH-1:0] num_u, den_u, num_mag, den_mag;
  logic                  num_neg, den_neg;

  // step unit results
  logic [DATA_WIDTH-1:0] rem_next;
  logic                  q_bit;

  // fixed-up result
  logic [DATA_WIDTH-1:0] q_neg;
  logic [DATA_WIDTH-1:0] result;

  assign accept = in_valid && in_ready;

  // magnitudes, the most negative value maps to 2^(DATA_WIDTH-1)
  assign num_u   = numerator;
  assign den_u   = denominator;
  assign num_neg = num_u[DATA_WIDTH-1];
  assign den_neg = den_u[DATA_WIDTH-1];
  assign num_mag = num_neg ? (~num_u) + ONE : num_u;
  assign den_mag = den_neg ? (~den_u) + ONE : den_u;

  // shared compare-subtract unit
  sdiv_step #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_step (
    .rem      (rem),
    .dd_bit   (dq[DATA_WIDTH-1]),
    .divisor  (divisor),
    .rem_next (rem_next),
    .q_bit    (q_bit)
  );

  // sign fix-up and saturation
  assign q_neg = (~dq) + ONE;
  always_comb begin
    if (div_zero) begin
      result = MAX_POS;
    end else if (neg) begin
      result = q_neg;
    end else if (dq[DATA_WIDTH-1]) begin
      result = MAX_POS;
    end else begin
      result = dq;
    end
  end

  // sequencer next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = load_out || (out_valid && !out_ready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dq       <= num_mag;
      rem      <= '0;
      divisor  <= den_mag;
      cnt      <= LAST_BIT;
      neg      <= num_neg ^ den_neg;
      div_zero <= (den_u == '0);
    end else if (state == ST_DIV) begin
      dq  <= {dq[DATA_WIDTH-2:0], q_bit};
      rem <= rem_next;
      cnt <= cnt - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      quotient <= result;
    end
  end

endmodule

// ===== hw/rtl/sdiv_checker.sv =====
// port-level checks for the saturating signed divider, bound to the top level
// depends on sdiv_pkg for the default width

module sdiv_checker #(
  parameter int DATA_WIDTH = sdiv_pkg::SDIV_DATA_WIDTH
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic signed [DATA_WIDTH-1:0] numerator,
  input logic signed [DATA_WIDTH-1:0] denominator,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] quotient
);
  import sdiv_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient))
    else $error("result dropped or changed while stalled");

  // the block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while divider busy");

  // every quotient bit takes a cycle, so still busy in the sign fix-up after the last step
  a_busy_full_length: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##(DATA_WIDTH + 1) !in_ready)
    else $error("divider finished too early");

  // a fresh result coincides with the sequencer going idle
  a_result_frees_unit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while divider still busy");

endmodule

bind signed_divider_saturating_unit sdiv_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_sdiv_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .numerator   (numerator),
  .denominator (denominator),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .quotient    (quotient)
);
